// ----- src/sfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the sync-word frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam logic [7:0]  SYNC_A         = 8'hAA;
	localparam logic [7:0]  SYNC_B         = 8'h44;
	localparam logic [7:0]  SYNC_LONG      = 8'h12;
	localparam logic [7:0]  SYNC_SHORT     = 8'h13;
	localparam logic [7:0]  SHORT_HDR_LEN  = 8'd12;
	localparam logic [7:0]  MIN_LONG_HDR   = 8'd10;
	localparam int          TRAILER_LEN    = 4;
	localparam int          IDX_W          = 17;
	localparam logic [31:0] CRC_POLY_RESET = 32'hEDB88320;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SYNC1 = 3'd1,
		PH_SYNC2 = 3'd2,
		PH_LONG  = 3'd3,
		PH_SHORT = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD      = 2'd0,
		ST_CRC_BAD   = 2'd1,
		ST_HDR_SHORT = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  frame_status;
		logic [15:0] message_id;
		logic        short_header;
		logic [15:0] message_length;
		logic [15:0] gps_week;
		logic [31:0] gps_time_ms;
	} result_t;

endpackage
`default_nettype wire

// ----- src/sfr_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface sfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_status;
	logic [15:0] message_id;
	logic        short_header;
	logic [15:0] message_length;
	logic [15:0] gps_week;
	logic [31:0] gps_time_ms;

	modport source (output valid, output frame_status, output message_id,
		output short_header, output message_length, output gps_week,
		output gps_time_ms, input ready);
	modport sink (input valid, input frame_status, input message_id,
		input short_header, input message_length, input gps_week,
		input gps_time_ms, output ready);
endinterface
`default_nettype wire

// ----- src/sync_frame_receiver_crc32_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc32_unit
// Hunts AA 44 12/13 sync words, follows each frame, checks its CRC-32 trailer.
// ----------------------------------------------------------------------------
// An accepted byte is registered, then processed by the frame FSM, whose 8-step
// CRC byte update is combinational; any result is registered in the output slot.
// Throughput: one byte per cycle, unless a result waits on a held output slot.
// Reset (arst_n low): hunt restarts from idle, all counters and captured fields
// clear, polynomial returns to 0xEDB88320.
module sync_frame_receiver_crc32_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [31:0]  cfg_wdata,
	sfr_byte_if.sink          rx,
	sfr_result_if.source      result
);

	logic              s1_valid_q;
	logic [7:0]        rx_byte_s1;
	logic [31:0]       poly_q;
	logic              out_valid_q;
	sfr_pkg::result_t  out_q;
	logic              emit;
	sfr_pkg::result_t  res;
	logic              go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= sfr_pkg::CRC_POLY_RESET;
		end else if (cfg_wen) begin
			poly_q <= cfg_wdata;
		end
	end

	// input byte proceeds unless it makes a result and the output slot is held
	assign go       = s1_valid_q && (!emit || !out_valid_q || result.ready);
	assign rx.ready = !s1_valid_q || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (rx.ready) begin
			s1_valid_q <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	sfr_frame_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (go),
		.b      (rx_byte_s1),
		.poly   (poly_q),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_q <= res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.frame_status   = out_q.frame_status;
	assign result.message_id     = out_q.message_id;
	assign result.short_header   = out_q.short_header;
	assign result.message_length = out_q.message_length;
	assign result.gps_week       = out_q.gps_week;
	assign result.gps_time_ms    = out_q.gps_time_ms;

endmodule
`default_nettype wire

// ----- src/sfr_crc_byte.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_crc_byte
// One-byte update of a reflected CRC-32 with a programmable polynomial.
// ----------------------------------------------------------------------------
module sfr_crc_byte (
	input  wire logic [31:0] crc_in,
	input  wire logic [7:0]  data,
	input  wire logic [31:0] poly,
	output logic [31:0]      crc_out
);

	always_comb begin
		logic [31:0] t;
		t = {24'd0, crc_in[7:0] ^ data};
		for (int k = 0; k < 8; k++) begin
			if (t[0]) begin
				t = (t >> 1) ^ poly;
			end else begin
				t = t >> 1;
			end
		end
		crc_out = {8'd0, crc_in[31:8]} ^ t;
	end

endmodule
`default_nettype wire

// ----- src/sfr_frame_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_frame_fsm
// Sync hunt, frame byte tracking, field capture, CRC and trailer check.
// ----------------------------------------------------------------------------
module sfr_frame_fsm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      b,
	input  wire logic [31:0]     poly,
	output logic                 emit,
	output sfr_pkg::result_t     res
);

	localparam int IW = sfr_pkg::IDX_W;

	sfr_pkg::phase_t ph_q, ph_d;
	logic [IW-1:0]   idx_q, idx_d;
	logic [IW-1:0]   frame_q, frame_d;
	logic [7:0]      hdr_q, hdr_d;
	logic [31:0]     crc_q, crc_d;
	logic [31:0]     trl_q, trl_d;
	logic [15:0]     id_q, id_d;
	logic [15:0]     len_q, len_d;
	logic [15:0]     week_q, week_d;
	logic [31:0]     time_q, time_d;

	logic [31:0]     crc_upd;
	logic [31:0]     crc_first;

	sfr_crc_byte u_crc_run (
		.crc_in  (crc_q),
		.data    (b),
		.poly    (poly),
		.crc_out (crc_upd)
	);

	// CRC of a lone first sync byte, seeded from zero
	sfr_crc_byte u_crc_first (
		.crc_in  (32'd0),
		.data    (b),
		.poly    (poly),
		.crc_out (crc_first)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= sfr_pkg::PH_IDLE;
			idx_q   <= '0;
			frame_q <= '0;
			hdr_q   <= '0;
			crc_q   <= '0;
			trl_q   <= '0;
			id_q    <= '0;
			len_q   <= '0;
			week_q  <= '0;
			time_q  <= '0;
		end else if (step) begin
			ph_q    <= ph_d;
			idx_q   <= idx_d;
			frame_q <= frame_d;
			hdr_q   <= hdr_d;
			crc_q   <= crc_d;
			trl_q   <= trl_d;
			id_q    <= id_d;
			len_q   <= len_d;
			week_q  <= week_d;
			time_q  <= time_d;
		end
	end

	always_comb begin
		logic          hunt;
		logic          restart;
		logic          in_body;
		logic [IW-1:0] body_end;
		logic [IW-1:0] idx_nx;
		logic [1:0]    pos;

		ph_d    = ph_q;
		idx_d   = idx_q;
		frame_d = frame_q;
		hdr_d   = hdr_q;
		crc_d   = crc_q;
		trl_d   = trl_q;
		id_d    = id_q;
		len_d   = len_q;
		week_d  = week_q;
		time_d  = time_q;
		emit    = 1'b0;
		res     = '0;
		hunt    = 1'b0;
		restart = 1'b0;

		body_end = frame_q - IW'(sfr_pkg::TRAILER_LEN);
		in_body  = (frame_q == '0) || (idx_q < body_end);
		idx_nx   = idx_q + IW'(1);
		pos      = 2'(idx_q - body_end);

		case (ph_q)
			sfr_pkg::PH_SYNC1: begin
				if (b == sfr_pkg::SYNC_B) begin
					ph_d  = sfr_pkg::PH_SYNC2;
					crc_d = crc_upd;
				end else begin
					hunt = 1'b1;
				end
			end
			sfr_pkg::PH_SYNC2: begin
				if (b == sfr_pkg::SYNC_LONG || b == sfr_pkg::SYNC_SHORT) begin
					ph_d  = (b == sfr_pkg::SYNC_SHORT) ? sfr_pkg::PH_SHORT
						: sfr_pkg::PH_LONG;
					crc_d = crc_upd;
					idx_d = IW'(3);
				end else begin
					hunt = 1'b1;
				end
			end
			sfr_pkg::PH_LONG, sfr_pkg::PH_SHORT: begin
				if (idx_q == IW'(3) && ph_q == sfr_pkg::PH_LONG && b < sfr_pkg::MIN_LONG_HDR) begin
					// long header too short: flag at once, no CRC update
					emit             = 1'b1;
					res.frame_status = sfr_pkg::ST_HDR_SHORT;
					restart          = 1'b1;
				end else begin
					if (idx_q == IW'(3)) begin
						if (ph_q == sfr_pkg::PH_SHORT) begin
							hdr_d       = sfr_pkg::SHORT_HDR_LEN;
							len_d[7:0]  = b;
							frame_d     = IW'(sfr_pkg::SHORT_HDR_LEN) + IW'(b)
								+ IW'(sfr_pkg::TRAILER_LEN);
						end else begin
							hdr_d = b;
						end
					end else if (in_body) begin
						case (idx_q)
							IW'(4):  id_d[7:0]    = b;
							IW'(5):  id_d[15:8]   = b;
							IW'(8):  if (ph_q == sfr_pkg::PH_LONG) len_d[7:0] = b;
							IW'(9): begin
								if (ph_q == sfr_pkg::PH_LONG) begin
									len_d[15:8] = b;
									frame_d = IW'(hdr_q) + IW'({b, len_q[7:0]})
										+ IW'(sfr_pkg::TRAILER_LEN);
								end
							end
							IW'(14): week_d[7:0]   = b;
							IW'(15): week_d[15:8]  = b;
							IW'(16): time_d[7:0]   = b;
							IW'(17): time_d[15:8]  = b;
							IW'(18): time_d[23:16] = b;
							IW'(19): time_d[31:24] = b;
							default: ;
						endcase
					end

					if (in_body) begin
						crc_d = crc_upd;
					end else begin
						trl_d = trl_q | ({24'd0, b} << {pos, 3'd0});
					end

					idx_d = idx_nx;
					if (frame_d != '0 && idx_nx == frame_d) begin
						emit                 = 1'b1;
						res.frame_status     = (crc_d == trl_d) ? sfr_pkg::ST_GOOD
							: sfr_pkg::ST_CRC_BAD;
						res.message_id       = id_d;
						res.short_header     = (ph_q == sfr_pkg::PH_SHORT);
						res.message_length   = len_d;
						res.gps_week         = week_d;
						res.gps_time_ms      = time_d;
						restart              = 1'b1;
					end
				end
			end
			default: begin
				hunt = 1'b1;
			end
		endcase

		if (hunt || restart) begin
			ph_d    = sfr_pkg::PH_IDLE;
			idx_d   = '0;
			frame_d = '0;
			hdr_d   = '0;
			crc_d   = '0;
			trl_d   = '0;
			id_d    = '0;
			len_d   = '0;
			week_d  = '0;
			time_d  = '0;
		end
		// a mismatched byte that is itself AA starts a new hunt
		if (hunt && b == sfr_pkg::SYNC_A) begin
			ph_d  = sfr_pkg::PH_SYNC1;
			crc_d = crc_first;
		end
	end

endmodule
`default_nettype wire

// ----- tb/tb_sync_frame_receiver_crc32_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_frame_receiver_crc32_unit
// Feeds framed and broken byte streams into the sync-word frame receiver.
// Predicts every frame result from its own copy of the hunt and CRC state,
// and checks each result field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_sync_frame_receiver_crc32_unit;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [31:0] cfg_wdata;

	sfr_byte_if   rx_ch();
	sfr_result_if res_ch();

	sync_frame_receiver_crc32_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.result    (res_ch)
	);

	// receiver image: hunt state, frame counters, captured fields
	logic [31:0]      crc_poly;
	sfr_pkg::phase_t  ph;
	logic [16:0]      pos;
	logic [7:0]       hdr_len;
	logic [16:0]      frame_len;
	logic [31:0]      crc_acc;
	logic [31:0]      trailer_acc;
	logic [15:0]      cap_id;
	logic [15:0]      cap_len;
	logic [15:0]      cap_week;
	logic [31:0]      cap_time;

	sfr_pkg::result_t pending_frames[$];
	logic [7:0]       frame_buf[$];

	int errors = 0;
	int bytes_sent = 0;
	int src_gap_max = 11;
	int sink_stall_max = 11;
	int hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] t;
		t = {24'd0, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++)
			t = t[0] ? ((t >> 1) ^ crc_poly) : (t >> 1);
		return {8'd0, crc[31:8]} ^ t;
	endfunction

	task automatic restart_hunt();
		ph = sfr_pkg::PH_IDLE;
		pos = '0;
		hdr_len = '0;
		frame_len = '0;
		crc_acc = '0;
		trailer_acc = '0;
		cap_id = '0;
		cap_len = '0;
		cap_week = '0;
		cap_time = '0;
	endtask

	task automatic hunt_first(input logic [7:0] b);
		restart_hunt();
		if (b == sfr_pkg::SYNC_A) begin
			ph = sfr_pkg::PH_SYNC1;
			crc_acc = crc_step(32'd0, b);
		end
	endtask

	task automatic push_result(input sfr_pkg::status_t st, input logic sh);
		sfr_pkg::result_t r;
		r.frame_status   = st;
		r.message_id     = cap_id;
		r.short_header   = sh;
		r.message_length = cap_len;
		r.gps_week       = cap_week;
		r.gps_time_ms    = cap_time;
		pending_frames.push_back(r);
	endtask

	task automatic track_frame_byte(input logic [7:0] b);
		int  i;
		int  tpos;
		bit  body;
		i = int'(pos);
		body = (frame_len == 0) || (i < int'(frame_len) - sfr_pkg::TRAILER_LEN);
		if (i == 3) begin
			if (ph == sfr_pkg::PH_SHORT) begin
				hdr_len = sfr_pkg::SHORT_HDR_LEN;
				cap_len[7:0] = b;
				frame_len = 17'(int'(sfr_pkg::SHORT_HDR_LEN) + int'(b)
					+ sfr_pkg::TRAILER_LEN);
			end else begin
				hdr_len = b;
				if (b < sfr_pkg::MIN_LONG_HDR) begin
					cap_id = '0;
					cap_len = '0;
					cap_week = '0;
					cap_time = '0;
					push_result(sfr_pkg::ST_HDR_SHORT, 1'b0);
					restart_hunt();
					return;
				end
			end
		end else if (body) begin
			case (i)
				4: cap_id[7:0] = b;
				5: cap_id[15:8] = b;
				8: if (ph == sfr_pkg::PH_LONG) cap_len[7:0] = b;
				9: if (ph == sfr_pkg::PH_LONG) begin
					cap_len[15:8] = b;
					frame_len = 17'(int'(hdr_len) + int'(cap_len) + sfr_pkg::TRAILER_LEN);
				end
				14: cap_week[7:0] = b;
				15: cap_week[15:8] = b;
				16: cap_time[7:0] = b;
				17: cap_time[15:8] = b;
				18: cap_time[23:16] = b;
				19: cap_time[31:24] = b;
				default: ;
			endcase
		end
		if (body) begin
			crc_acc = crc_step(crc_acc, b);
		end else begin
			tpos = (i - (int'(frame_len) - sfr_pkg::TRAILER_LEN)) & 3;
			trailer_acc = trailer_acc | (32'(b) << (8 * tpos));
		end
		pos = 17'(i + 1);
		if (frame_len != 0 && pos == frame_len) begin
			push_result((crc_acc == trailer_acc) ? sfr_pkg::ST_GOOD : sfr_pkg::ST_CRC_BAD,
				ph == sfr_pkg::PH_SHORT);
			restart_hunt();
		end
	endtask

	task automatic track_byte(input logic [7:0] b);
		case (ph)
			sfr_pkg::PH_SYNC1: begin
				if (b == sfr_pkg::SYNC_B) begin
					ph = sfr_pkg::PH_SYNC2;
					crc_acc = crc_step(crc_acc, b);
				end else begin
					hunt_first(b);
				end
			end
			sfr_pkg::PH_SYNC2: begin
				if (b == sfr_pkg::SYNC_LONG || b == sfr_pkg::SYNC_SHORT) begin
					ph = (b == sfr_pkg::SYNC_SHORT) ? sfr_pkg::PH_SHORT : sfr_pkg::PH_LONG;
					crc_acc = crc_step(crc_acc, b);
					pos = 17'd3;
				end else begin
					hunt_first(b);
				end
			end
			sfr_pkg::PH_LONG, sfr_pkg::PH_SHORT: track_frame_byte(b);
			default: hunt_first(b);
		endcase
	endtask

	// random data byte, leaning toward the sync values
	function automatic logic [7:0] payload_byte();
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: return sfr_pkg::SYNC_A;
				1: return sfr_pkg::SYNC_B;
				2: return sfr_pkg::SYNC_LONG;
				default: return sfr_pkg::SYNC_SHORT;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	// noise that opens a long frame gets a zero message length
	function automatic logic [7:0] noise_byte();
		if (ph == sfr_pkg::PH_LONG && (pos == 17'd8 || pos == 17'd9))
			return 8'h00;
		return payload_byte();
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		track_byte(b);
	endtask

	// long headers below the minimum stop after the header length byte
	task automatic build_frame(input bit is_short, input logic [7:0] hdr, input logic [15:0] len,
			input logic [15:0] id, input logic [15:0] week, input logic [31:0] tms,
			input bit bad_crc);
		int          n;
		logic [7:0]  v;
		logic [31:0] crc;
		frame_buf.delete();
		if (!is_short && hdr < sfr_pkg::MIN_LONG_HDR) begin
			frame_buf = '{sfr_pkg::SYNC_A, sfr_pkg::SYNC_B, sfr_pkg::SYNC_LONG, hdr};
			return;
		end
		n = is_short ? (int'(sfr_pkg::SHORT_HDR_LEN) + int'(len[7:0]))
			: (int'(hdr) + int'(len));
		crc = '0;
		for (int j = 0; j < n; j++) begin
			v = payload_byte();
			case (j)
				0: v = sfr_pkg::SYNC_A;
				1: v = sfr_pkg::SYNC_B;
				2: v = is_short ? sfr_pkg::SYNC_SHORT : sfr_pkg::SYNC_LONG;
				3: v = is_short ? len[7:0] : hdr;
				4: v = id[7:0];
				5: v = id[15:8];
				8: if (!is_short) v = len[7:0];
				9: if (!is_short) v = len[15:8];
				14: v = week[7:0];
				15: v = week[15:8];
				16: v = tms[7:0];
				17: v = tms[15:8];
				18: v = tms[23:16];
				19: v = tms[31:24];
				default: ;
			endcase
			frame_buf.push_back(v);
			crc = crc_step(crc, v);
		end
		if (bad_crc)
			crc = crc ^ ($urandom() | 32'd1);
		for (int j = 0; j < 4; j++)
			frame_buf.push_back(crc[8*j +: 8]);
	endtask

	task automatic send_frame(input bit is_short, input logic [7:0] hdr, input logic [15:0] len,
			input logic [15:0] id, input logic [15:0] week, input logic [31:0] tms,
			input bit bad_crc);
		build_frame(is_short, hdr, len, id, week, tms, bad_crc);
		foreach (frame_buf[j])
			send_byte(frame_buf[j]);
	endtask

	task automatic send_random_frame(input bit bad_crc);
		bit          sh;
		logic [7:0]  hdr;
		logic [15:0] len;
		sh = $urandom_range(1);
		hdr = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 10)) : 8'($urandom_range(28, 10));
		if (sh)
			len = ($urandom_range(19) == 0) ? 16'($urandom_range(255)) : 16'($urandom_range(24));
		else
			len = ($urandom_range(29) == 0) ? 16'($urandom_range(700)) : 16'($urandom_range(24));
		send_frame(sh, hdr, len, 16'($urandom()), 16'($urandom()), $urandom(), bad_crc);
	endtask

	// a frame left open by noise would swallow the next one
	task automatic close_open_frame();
		while (ph == sfr_pkg::PH_LONG || ph == sfr_pkg::PH_SHORT)
			send_byte(noise_byte());
	endtask

	task automatic wait_idle();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_poly(input logic [31:0] p);
		close_open_frame();
		wait_idle();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_wen <= 1'b0;
		crc_poly = p;
	endtask

	task automatic test_frame_layouts();
		src_gap_max = 11;
		sink_stall_max = 11;
		// short frames: time words absent, partly present, present, then max length and a bad CRC
		send_frame(1, 8'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send_frame(1, 8'd0, 16'd5, 16'h1234, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send_frame(1, 8'd0, 16'd8, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send_frame(1, 8'd0, 16'd255, 16'h0000, 16'h0000, 32'h0000_0000, 0);
		send_frame(1, 8'd0, 16'd12, 16'hA5A5, 16'h5A5A, 32'hDEAD_BEEF, 1);
		// long frames: shortest legal header, week only, fields at max with bad CRC
		send_frame(0, 8'd10, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send_frame(0, 8'd10, 16'd6, 16'h8001, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send_frame(0, 8'd28, 16'd24, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1);
		send_frame(0, 8'd20, 16'd30, 16'h0000, 16'h0000, 32'h0000_0000, 0);
		// header length below the minimum
		send_frame(0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0, 0);
		send_frame(0, 8'd9, 16'd0, 16'd0, 16'd0, 32'd0, 0);
	endtask

	task automatic test_sync_hunt();
		// repeated AA restarts the hunt on itself
		send_byte(sfr_pkg::SYNC_A);
		send_frame(1, 8'd0, 16'd3, 16'($urandom()), 16'($urandom()), $urandom(), 0);
		send_byte(sfr_pkg::SYNC_A);
		send_byte(sfr_pkg::SYNC_B);
		send_frame(0, 8'd16, 16'd4, 16'($urandom()), 16'($urandom()), $urandom(), 0);
		send_byte(sfr_pkg::SYNC_A);
		send_byte(sfr_pkg::SYNC_B);
		send_byte(sfr_pkg::SYNC_B);
		send_frame(1, 8'd0, 16'd20, 16'($urandom()), 16'($urandom()), $urandom(), 0);
		send_byte(sfr_pkg::SYNC_A);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(sfr_pkg::SYNC_B);
		send_byte(sfr_pkg::SYNC_LONG);
		send_byte(sfr_pkg::SYNC_SHORT);
		send_byte(sfr_pkg::SYNC_A);
		send_byte(sfr_pkg::SYNC_B);
		send_byte(8'hFF);
		send_frame(0, 8'd12, 16'd2, 16'($urandom()), 16'($urandom()), $urandom(), 0);
	endtask

	task automatic test_crc_polynomial();
		logic [31:0] polys[4];
		polys = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), sfr_pkg::CRC_POLY_RESET};
		foreach (polys[j]) begin
			load_poly(polys[j]);
			send_frame(1, 8'd0, 16'($urandom_range(20)), 16'($urandom()), 16'($urandom()),
				$urandom(), 0);
			send_frame(0, 8'($urandom_range(24, 10)), 16'($urandom_range(20)), 16'($urandom()),
				16'($urandom()), $urandom(), 0);
			send_frame(1, 8'd0, 16'($urandom_range(20)), 16'($urandom()), 16'($urandom()),
				$urandom(), 1);
		end
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		src_gap_max = 0;
		hold_request = 400;
		repeat (8)
			send_frame(1, 8'd0, 16'($urandom_range(3)), 16'($urandom()), 16'($urandom()),
				$urandom(), $urandom_range(3) == 0);
		wait_idle();
		src_gap_max = 11;
	endtask

	task automatic test_random_traffic();
		int start_bytes;
		int r;
		bit poly_changed;
		start_bytes = bytes_sent;
		poly_changed = 0;
		while (bytes_sent - start_bytes < 200) begin
			if ($urandom_range(3) == 0)
				src_gap_max = $urandom_range(1) ? 11 : 0;
			if ($urandom_range(3) == 0)
				sink_stall_max = $urandom_range(1) ? 11 : 0;
			if (!poly_changed && bytes_sent - start_bytes > 100) begin
				load_poly($urandom());
				poly_changed = 1;
			end
			close_open_frame();
			r = $urandom_range(99);
			if (r < 62) begin
				send_random_frame($urandom_range(6) == 0);
			end else if (r < 70) begin
				send_frame(0, 8'($urandom_range(9)), 16'd0, 16'd0, 16'd0, 32'd0, 0);
			end else if (r < 82) begin
				// broken sync run: AA, maybe 44, then AA or a random byte that is never 12 or 13
				send_byte(sfr_pkg::SYNC_A);
				if ($urandom_range(1))
					send_byte(sfr_pkg::SYNC_B);
				send_byte($urandom_range(1) ? sfr_pkg::SYNC_A : 8'($urandom_range(255, 20)));
			end else begin
				repeat ($urandom_range(8, 1))
					send_byte(noise_byte());
			end
		end
	endtask

	function automatic string fmt_result(input sfr_pkg::result_t r);
		return $sformatf("status %0d id %h short %0d len %h week %h time %h",
			r.frame_status, r.message_id, r.short_header, r.message_length,
			r.gps_week, r.gps_time_ms);
	endfunction

	initial begin : result_sink
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else begin
				stall = $urandom_range(sink_stall_max);
			end
			@(negedge clk);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready) && hold_request == 0);
		end
	end

	initial begin : result_check
		sfr_pkg::result_t got;
		sfr_pkg::result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got.frame_status   = res_ch.frame_status;
				got.message_id     = res_ch.message_id;
				got.short_header   = res_ch.short_header;
				got.message_length = res_ch.message_length;
				got.gps_week       = res_ch.gps_week;
				got.gps_time_ms    = res_ch.gps_time_ms;
				if (pending_frames.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: %s", fmt_result(got));
				end else begin
					want = pending_frames.pop_front();
					if (got.frame_status !== want.frame_status
							|| got.message_id !== want.message_id
							|| got.short_header !== want.short_header
							|| got.message_length !== want.message_length
							|| got.gps_week !== want.gps_week
							|| got.gps_time_ms !== want.gps_time_ms) begin
						errors++;
						if (errors <= 10) begin
							$display("result mismatch at %0t", $time);
							$display("  expected %s", fmt_result(want));
							$display("  actual   %s", fmt_result(got));
						end
					end
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_sync_frame_receiver_crc32_unit failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		crc_poly = sfr_pkg::CRC_POLY_RESET;
		restart_hunt();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_frame_layouts();
		test_sync_hunt();
		test_crc_polynomial();
		test_output_backpressure();
		test_random_traffic();

		@(negedge clk);
		rx_ch.valid <= 1'b0;
		for (int c = 0; c < 20000 && pending_frames.size() != 0; c++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_frames.size() != 0) begin
			errors += pending_frames.size();
			$display("%0d expected results never arrived", pending_frames.size());
		end

		if (errors == 0)
			$display("tb_sync_frame_receiver_crc32_unit passed");
		else
			$display("tb_sync_frame_receiver_crc32_unit failed");
		$finish;
	end

endmodule

// ----- files.f -----
src/sfr_pkg.sv
src/sfr_if.sv
src/sfr_crc_byte.sv
src/sfr_frame_fsm.sv
src/sync_frame_receiver_crc32_unit.sv
tb/tb_sync_frame_receiver_crc32_unit.sv
